// ----- hw/rtl/pbaa_pkg.sv -----
package pbaa_pkg;

	// Field and position widths fixed by the interface
	localparam int unsigned DATA_W   = 64;
	localparam int unsigned INDEX_W  = 16;
	localparam int unsigned EBITS_W  = 7;
	localparam int unsigned OFF_W    = 6;
	// bit position of an element: index * width, plus one bit of headroom for the end
	localparam int unsigned POS_W    = INDEX_W + EBITS_W;
	// word number taken from a bit position
	localparam int unsigned WORD_W   = POS_W - OFF_W;
	// element width after reset
	localparam logic [EBITS_W-1:0] EBITS_RESET = EBITS_W'(8);
	// command queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic {
		OP_READ  = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	// one classified request, ready for the back end
	typedef struct packed {
		op_t                op;
		logic               oor;
		logic               spans;
		logic [OFF_W-1:0]   off;
		logic [WORD_W-1:0]  word;
		logic [DATA_W-1:0]  mask;
		logic [DATA_W-1:0]  value;
	} pbaa_cmd_t;

endpackage

// ----- hw/rtl/pbaa_front.sv -----
module pbaa_front #(
	parameter int unsigned STORE_WORDS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [pbaa_pkg::EBITS_W-1:0]  cfg_write_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          operation,
	input  logic [pbaa_pkg::INDEX_W-1:0]  element_index,
	input  logic [pbaa_pkg::DATA_W-1:0]   write_value,
	input  logic                          q_full,
	input  logic                          clearing,
	output logic                          q_push,
	output pbaa_pkg::pbaa_cmd_t           q_cmd
);
	import pbaa_pkg::*;

	// total store size in bits
	localparam logic [POS_W:0] LIMIT = (POS_W + 1)'(STORE_WORDS * DATA_W);

	logic [EBITS_W-1:0] element_bits_q;
	logic [EBITS_W-1:0] width;
	logic [DATA_W-1:0]  mask;
	logic [POS_W-1:0]   start_pos;
	logic [POS_W:0]     end_pos;
	logic [EBITS_W-1:0] off_plus_w;

	// width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_bits_q <= EBITS_RESET;
		end else if (cfg_write_en) begin
			element_bits_q <= cfg_write_data;
		end
	end

	// effective width: zero reads as one, above 64 as 64
	always_comb begin
		if (element_bits_q == '0) begin
			width = EBITS_W'(1);
		end else if (element_bits_q > EBITS_W'(DATA_W)) begin
			width = EBITS_W'(DATA_W);
		end else begin
			width = element_bits_q;
		end
	end

	assign mask = width[OFF_W] ? '1 : ((DATA_W'(1) << width[OFF_W-1:0]) - DATA_W'(1));

	// element placement and range check
	assign start_pos  = POS_W'(element_index) * POS_W'(width);
	assign end_pos    = (POS_W + 1)'(start_pos) + (POS_W + 1)'(width);
	assign off_plus_w = EBITS_W'(start_pos[OFF_W-1:0]) + width;

	assign in_stall = q_full | clearing;
	assign q_push   = in_valid & ~in_stall;

	always_comb begin
		q_cmd.op    = op_t'(operation);
		q_cmd.oor   = end_pos > LIMIT;
		q_cmd.spans = off_plus_w > EBITS_W'(DATA_W);
		q_cmd.off   = start_pos[OFF_W-1:0];
		q_cmd.word  = start_pos[POS_W-1:OFF_W];
		q_cmd.mask  = mask;
		q_cmd.value = write_value & mask;
	end

endmodule

// ----- hw/rtl/pbaa_queue.sv -----
module pbaa_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  pbaa_pkg::pbaa_cmd_t  push_cmd,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_valid,
	output pbaa_pkg::pbaa_cmd_t  head_cmd
);
	import pbaa_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

	pbaa_cmd_t              slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [PTR_W:0]         count_q;

	assign full       = count_q == (PTR_W + 1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd   = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_W + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_W + 1)'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/pbaa_back.sv -----
module pbaa_back #(
	parameter int unsigned STORE_WORDS = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  pbaa_pkg::pbaa_cmd_t          head_cmd,
	output logic                         pop,
	output logic                         clearing,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [pbaa_pkg::DATA_W-1:0]  read_value,
	output logic                         out_of_range
);
	import pbaa_pkg::*;

	localparam int unsigned AW = $clog2(STORE_WORDS);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_GET0  = 5'b00100,
		ST_RD1   = 5'b01000,
		ST_GET1  = 5'b10000
	} state_t;

	state_t             state_q, state_d;
	pbaa_cmd_t          cmd_q;
	logic [DATA_W-1:0]  lo_q;
	logic [DATA_W-1:0]  rdata_q;
	logic [AW-1:0]      clr_addr_q;
	logic               out_valid_q;
	logic [DATA_W-1:0]  read_value_q;
	logic               out_of_range_q;

	logic               mem_en, mem_we;
	logic [AW-1:0]      mem_addr;
	logic [DATA_W-1:0]  mem_wdata;
	logic               out_free;
	logic               load_out;
	logic [DATA_W-1:0]  res_value;
	logic               res_oor;
	logic [AW-1:0]      addr0, addr1;
	logic [EBITS_W-1:0] hi_sh;
	logic [DATA_W-1:0]  merge0, merge1, rd_one, rd_two;

	logic [DATA_W-1:0]  mem [STORE_WORDS];

	// single-port word store, registered read
	always_ff @(posedge clk) begin
		if (mem_en) begin
			if (mem_we) begin
				mem[mem_addr] <= mem_wdata;
			end else begin
				rdata_q <= mem[mem_addr];
			end
		end
	end

	assign addr0 = cmd_q.word[AW-1:0];
	assign addr1 = addr0 + AW'(1);
	// shift for the upper part of a spanning element; off is never zero then
	assign hi_sh = EBITS_W'(DATA_W) - EBITS_W'(cmd_q.off);

	// word merges and read extraction
	assign merge0 = (rdata_q & ~(cmd_q.mask << cmd_q.off)) | (cmd_q.value << cmd_q.off);
	assign merge1 = (rdata_q & ~(cmd_q.mask >> hi_sh)) | (cmd_q.value >> hi_sh);
	assign rd_one = (rdata_q >> cmd_q.off) & cmd_q.mask;
	assign rd_two = ((lo_q >> cmd_q.off) | (rdata_q << hi_sh)) & cmd_q.mask;

	assign out_free = ~out_valid_q | ~out_stall;
	assign clearing = state_q == ST_CLEAR;

	// sequencer
	always_comb begin
		state_d   = state_q;
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = addr0;
		mem_wdata = '0;
		pop       = 1'b0;
		load_out  = 1'b0;
		res_value = '0;
		res_oor   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_en   = 1'b1;
				mem_we   = 1'b1;
				mem_addr = clr_addr_q;
				if (clr_addr_q == AW'(STORE_WORDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (head_valid && out_free) begin
					pop = 1'b1;
					if (head_cmd.oor) begin
						load_out = 1'b1;
						res_oor  = 1'b1;
					end else begin
						mem_en   = 1'b1;
						mem_addr = head_cmd.word[AW-1:0];
						state_d  = ST_GET0;
					end
				end
			end
			ST_GET0: begin
				if (cmd_q.op == OP_WRITE) begin
					mem_en    = 1'b1;
					mem_we    = 1'b1;
					mem_wdata = merge0;
					if (cmd_q.spans) begin
						state_d = ST_RD1;
					end else begin
						load_out = 1'b1;
						state_d  = ST_IDLE;
					end
				end else if (cmd_q.spans) begin
					mem_en   = 1'b1;
					mem_addr = addr1;
					state_d  = ST_GET1;
				end else begin
					load_out  = 1'b1;
					res_value = rd_one;
					state_d   = ST_IDLE;
				end
			end
			ST_RD1: begin
				mem_en   = 1'b1;
				mem_addr = addr1;
				state_d  = ST_GET1;
			end
			ST_GET1: begin
				load_out = 1'b1;
				state_d  = ST_IDLE;
				if (cmd_q.op == OP_WRITE) begin
					mem_en    = 1'b1;
					mem_we    = 1'b1;
					mem_addr  = addr1;
					mem_wdata = merge1;
				end else begin
					res_value = rd_two;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head_cmd;
		end
		if (state_q == ST_GET0) begin
			lo_q <= rdata_q;
		end
		if (load_out) begin
			read_value_q   <= res_value;
			out_of_range_q <= res_oor;
		end
	end

	assign out_valid    = out_valid_q;
	assign read_value   = read_value_q;
	assign out_of_range = out_of_range_q;

endmodule

// ----- hw/rtl/packed_bit_array_access.sv -----
// Channel   Handshake            Payload
// config    cfg_write_en         cfg_write_data (element width)
// in        in_valid / in_stall  operation, element_index, write_value
// out       out_valid / out_stall read_value, out_of_range
//
// An in-word request reads its word, then returns the field or writes
// the merge back; across two words a read also reads the next word and
// a write reads and rewrites it after writing the first. Out-of-range
// requests skip the store. After reset a clearing pass zeroes the store
// word by word, with in_stall held high. A two-entry queue keeps taking
// requests while the back end works or its result waits on out_stall.
module packed_bit_array_access #(
	parameter int unsigned STORE_WORDS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [pbaa_pkg::EBITS_W-1:0]  cfg_write_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          operation,
	input  logic [pbaa_pkg::INDEX_W-1:0]  element_index,
	input  logic [pbaa_pkg::DATA_W-1:0]   write_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pbaa_pkg::DATA_W-1:0]   read_value,
	output logic                          out_of_range
);
	import pbaa_pkg::*;

	logic      q_full, q_push, q_pop, head_valid, clearing;
	pbaa_cmd_t push_cmd, head_cmd;

	// classify requests
	pbaa_front #(
		.STORE_WORDS (STORE_WORDS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.element_index  (element_index),
		.write_value    (write_value),
		.q_full         (q_full),
		.clearing       (clearing),
		.q_push         (q_push),
		.q_cmd          (push_cmd)
	);

	// decoupling queue
	pbaa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// memory access and results
	pbaa_back #(
		.STORE_WORDS (STORE_WORDS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_cmd     (head_cmd),
		.pop          (q_pop),
		.clearing     (clearing),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_value   (read_value),
		.out_of_range (out_of_range)
	);

	// an out-of-range result never carries data
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> read_value == '0)
		else $error("out-of-range result with nonzero data");

	// no request taken while the store is being cleared
	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> in_stall)
		else $error("request accepted during clearing pass");

	// back end only starts a request when the result slot is free
	a_pop_slot: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (!out_valid || !out_stall))
		else $error("request started with result slot blocked");

	// nothing reaches the output before the clearing pass ends
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !out_valid)
		else $error("result during clearing pass");

endmodule

// ----- dv/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pbaa_pkg::*;

	localparam int unsigned STORE_WORDS   = 1024;
	localparam int unsigned STALL_LIMIT   = 4000;
	localparam int unsigned REPORT_LIMIT  = 10;
	localparam int unsigned DIRECTED_ROWS = 24;
	localparam int unsigned PHASES        = 8;
	localparam int unsigned PHASE_ITEMS   = 88;
	localparam int unsigned DRAIN_CYCLES  = 8;

	typedef struct packed {
		logic [DATA_W-1:0] read_value;
		logic              out_of_range;
	} access_result_t;

	typedef struct {
		logic [EBITS_W-1:0] width;
		op_t                op;
		logic [INDEX_W-1:0] index;
		logic [DATA_W-1:0]  value;
		bit                 typed;
		logic [DATA_W-1:0]  read_value;
		bit                 out_of_range;
	} access_row_t;

	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                cfg_write_en   = 1'b0;
	logic [EBITS_W-1:0]  cfg_write_data = '0;
	logic                in_valid       = 1'b0;
	logic                in_stall;
	logic                operation      = 1'b0;
	logic [INDEX_W-1:0]  element_index  = '0;
	logic [DATA_W-1:0]   write_value    = '0;
	logic                out_valid;
	logic                out_stall      = 1'b0;
	logic [DATA_W-1:0]   read_value;
	logic                out_of_range;

	// shadow of the packed store and of the width register
	logic [DATA_W-1:0]   shadow_words [STORE_WORDS];
	logic [EBITS_W-1:0]  width_setting = EBITS_RESET;

	access_result_t      pending_results [$];
	access_row_t         access_rows [DIRECTED_ROWS];
	int unsigned         sender_idle_pct    = 0;
	int unsigned         receiver_stall_pct = 0;
	int unsigned         mismatch_count     = 0;
	int unsigned         quiet_cycles       = 0;

	packed_bit_array_access #(
		.STORE_WORDS(STORE_WORDS)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.element_index (element_index),
		.write_value   (write_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.read_value    (read_value),
		.out_of_range  (out_of_range)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// width as the block applies it: zero reads as one, above 64 as 64
	function automatic int unsigned applied_width();
		if (width_setting == 0)
			return 1;
		if (width_setting > 64)
			return 64;
		return width_setting;
	endfunction

	// work out the result of one request and update the shadow store
	function automatic access_result_t predict_access(op_t op, logic [INDEX_W-1:0] index,
			logic [DATA_W-1:0] value);
		int unsigned       w;
		int unsigned       first_bit;
		int unsigned       word;
		int unsigned       off;
		int unsigned       sh;
		logic [DATA_W-1:0] mask;
		logic [DATA_W-1:0] masked;
		access_result_t    res;
		w = applied_width();
		mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
		first_bit = index * w;
		res.read_value = '0;
		res.out_of_range = 1'b0;
		if (first_bit + w > STORE_WORDS * 64) begin
			res.out_of_range = 1'b1;
			return res;
		end
		word = first_bit >> 6;
		off = first_bit & 63;
		sh = 64 - off;
		if (op == OP_READ) begin
			res.read_value = shadow_words[word] >> off;
			if (off + w > 64)
				res.read_value |= shadow_words[word + 1] << sh;
			res.read_value &= mask;
		end else begin
			masked = value & mask;
			shadow_words[word] = (shadow_words[word] & ~(mask << off)) | (masked << off);
			if (off + w > 64)
				shadow_words[word + 1] = (shadow_words[word + 1] & ~(mask >> sh))
					| (masked >> sh);
		end
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%0t: mismatch: %s", $realtime, msg);
	endtask

	// drive one request, entered and left at a falling edge
	task automatic send_request(op_t op, logic [INDEX_W-1:0] index, logic [DATA_W-1:0] value,
			bit typed, logic [DATA_W-1:0] typed_read, bit typed_oor);
		access_result_t res;
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= op;
		element_index <= index;
		write_value   <= value;
		do
			@(posedge clk);
		while (in_stall);
		res = predict_access(op, index, value);
		if (typed) begin
			res.read_value = typed_read;
			res.out_of_range = typed_oor;
		end
		pending_results.push_back(res);
		@(negedge clk);
	endtask

	// width change, only once the block has drained
	task automatic write_width(logic [EBITS_W-1:0] w);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= w;
		width_setting = w;
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	function automatic logic [INDEX_W-1:0] pick_index();
		int unsigned top;
		int unsigned pick;
		int          near;
		top = 65536 / applied_width() - 1;
		pick = $urandom_range(99);
		if (pick < 50)
			return INDEX_W'($urandom_range((top < 63) ? top : 63, 0));
		if (pick < 85)
			return INDEX_W'($urandom_range(top, 0));
		if (pick < 95) begin
			// around the end of the store
			near = int'(top) + int'($urandom_range(4)) - 2;
			if (near > 65535)
				near = 65535;
			return INDEX_W'(near);
		end
		return INDEX_W'($urandom_range(65535));
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 10)
			return '1;
		if (pick < 15)
			return '0;
		return {$urandom, $urandom};
	endfunction

	// receiver back-pressure
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		access_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result read_value=%h out_of_range=%b",
					read_value, out_of_range));
			end else begin
				want = pending_results.pop_front();
				if (read_value !== want.read_value)
					report_mismatch($sformatf("read_value expected %h got %h",
						want.read_value, read_value));
				if (out_of_range !== want.out_of_range)
					report_mismatch($sformatf("out_of_range expected %b got %b",
						want.out_of_range, out_of_range));
			end
		end
	end

	// watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [EBITS_W-1:0] phase_widths [PHASES];
		access_row_t        row;
		op_t                op;

		foreach (shadow_words[i])
			shadow_words[i] = '0;
		phase_widths = '{7'd1, 7'd64, 7'd13, 7'd63, 7'd0, 7'd127, 7'd33, 7'd8};

		// width, op, index, value, typed, read_value, out_of_range
		access_rows = '{
			'{7'd8,   OP_READ,  16'd0,     64'h0,                   1, 64'h0,  0},
			'{7'd8,   OP_READ,  16'd8191,  64'h0,                   1, 64'h0,  0},
			'{7'd8,   OP_READ,  16'd8192,  64'h0,                   1, 64'h0,  1},
			'{7'd8,   OP_WRITE, 16'd65535, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'h0,  1},
			'{7'd8,   OP_WRITE, 16'd0,     64'hFFFF_FFFF_FFFF_FFFF, 1, 64'h0,  0},
			'{7'd8,   OP_READ,  16'd0,     64'h0,                   1, 64'hFF, 0},
			'{7'd8,   OP_WRITE, 16'd8191,  64'hA5,                  1, 64'h0,  0},
			'{7'd8,   OP_READ,  16'd8191,  64'h0,                   1, 64'hA5, 0},
			// full width reinterprets the bytes written above
			'{7'd64,  OP_READ,  16'd0,     64'h0,                   0, 64'h0,  0},
			'{7'd64,  OP_WRITE, 16'd1023,  64'hFFFF_FFFF_FFFF_FFFF, 1, 64'h0,  0},
			'{7'd64,  OP_READ,  16'd1023,  64'h0,                   1, 64'hFFFF_FFFF_FFFF_FFFF, 0},
			'{7'd64,  OP_READ,  16'd1024,  64'h0,                   1, 64'h0,  1},
			// zero width acts as one bit
			'{7'd0,   OP_WRITE, 16'd65535, 64'hFFFF_FFFF_FFFF_FFFE, 1, 64'h0,  0},
			'{7'd0,   OP_READ,  16'd65535, 64'h0,                   0, 64'h0,  0},
			'{7'd0,   OP_READ,  16'd3,     64'h0,                   0, 64'h0,  0},
			// oversized width clamps to 64
			'{7'd127, OP_READ,  16'd1023,  64'h0,                   0, 64'h0,  0},
			'{7'd127, OP_WRITE, 16'd1024,  64'hFFFF_FFFF_FFFF_FFFF, 1, 64'h0,  1},
			// element straddling two words
			'{7'd63,  OP_WRITE, 16'd1,     64'hFFFF_FFFF_FFFF_FFFF, 1, 64'h0,  0},
			'{7'd63,  OP_READ,  16'd1,     64'h0,                   0, 64'h0,  0},
			'{7'd63,  OP_READ,  16'd0,     64'h0,                   0, 64'h0,  0},
			'{7'd65,  OP_READ,  16'd0,     64'h0,                   0, 64'h0,  0},
			'{7'd1,   OP_READ,  16'd64,    64'h0,                   0, 64'h0,  0},
			'{7'd13,  OP_WRITE, 16'd4,     64'h1234_5678_9ABC_DEF0, 1, 64'h0,  0},
			'{7'd13,  OP_READ,  16'd4,     64'h0,                   0, 64'h0,  0}
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed requests, no idling
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			row = access_rows[i];
			if (row.width != width_setting)
				write_width(row.width);
			send_request(row.op, row.index, row.value, row.typed, row.read_value,
				row.out_of_range);
		end

		// random requests, one width and one idling pattern per phase
		for (int p = 0; p < PHASES; p++) begin
			write_width(phase_widths[p]);
			case (p % 4)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 64;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 64;
				end
				default: begin
					sender_idle_pct = 30;
					receiver_stall_pct = 30;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				op = ($urandom_range(1) == 0) ? OP_READ : OP_WRITE;
				send_request(op, pick_index(), pick_value(), 0, '0, 0);
			end
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

		if (mismatch_count == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
